### hw/rtl/frdc_pkg.sv
// Package with shared types, codes and constants of the fuzzy rule duty controller.
`default_nettype none
package frdc_pkg;

    localparam int RULE_SLOTS_DEF = 16;
    localparam logic [16:0] DEG_ONE = 17'd32768;
    localparam logic [16:0] DEG_TWO = 17'd65536;

    typedef enum logic [1:0] {
        OP_WR_TEMP  = 2'd0,
        OP_WR_DELTA = 2'd1,
        OP_WR_SING  = 2'd2,
        OP_EVAL     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SHAPE_ABSENT = 2'd0,
        SHAPE_TRI    = 2'd1,
        SHAPE_HALF   = 2'd2,
        SHAPE_TRAP   = 2'd3
    } shape_t;

    typedef enum logic [1:0] {
        REG_RULES = 2'd0,
        REG_STEP  = 2'd1,
        REG_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_TSETUP,
        ST_TDIV,
        ST_DSETUP,
        ST_DDIV,
        ST_ACC,
        ST_MUL,
        ST_FDIV,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         rule_index;
        logic [1:0]         shape_kind;
        logic signed [15:0] range_from;
        logic signed [15:0] peak_from;
        logic signed [15:0] peak_to;
        logic signed [15:0] range_to;
        logic [15:0]        singleton;
        logic signed [15:0] temperature;
        logic signed [15:0] delta_temp;
    } cmd_t;

    typedef struct packed {
        logic [31:0] duty_cycle;
        logic [7:0]  error_total;
        logic        no_weight;
        logic        over_temp;
    } res_t;

    // Outcome of shape analysis: either a fixed degree, or a slope ratio.
    typedef struct packed {
        logic        fixed;
        logic [16:0] deg;
        logic        bad;
        logic [16:0] num;
        logic [16:0] den;
    } mship_t;

    // Slope num/den with saturation, as the shape rules require.
    function automatic mship_t slope_prep(input logic signed [17:0] num,
                                          input logic signed [17:0] den);
        mship_t m;
        m = '0;
        if (den <= 18'sd0 || num >= den) begin
            m.fixed = 1'b1;
            m.deg = DEG_ONE;
        end
        else if (num <= 18'sd0) begin
            m.fixed = 1'b1;
            m.deg = '0;
        end
        else begin
            m.num = num[16:0];
            m.den = den[16:0];
        end
        return m;
    endfunction

    function automatic mship_t shape_eval(input logic [1:0] kind,
                                          input logic [63:0] pts,
                                          input logic signed [15:0] xi);
        logic signed [17:0] rf;
        logic signed [17:0] mf;
        logic signed [17:0] mt;
        logic signed [17:0] rt;
        logic signed [17:0] x;
        mship_t m;
        rf = 18'(signed'(pts[15:0]));
        mf = 18'(signed'(pts[31:16]));
        mt = 18'(signed'(pts[47:32]));
        rt = 18'(signed'(pts[63:48]));
        x  = 18'(xi);
        m = '0;
        m.fixed = 1'b1;
        unique case (shape_t'(kind))
            SHAPE_TRI: begin
                if (x < rf || x > rt) m.deg = '0;
                else if (x <= mf) m = slope_prep(x - rf, mf - rf);
                else m = slope_prep(rt - x, rt - mf);
            end
            SHAPE_HALF: begin
                if (rf == mf) begin
                    if (x < rf) m.deg = DEG_ONE;
                    else if (x > rt) m.deg = '0;
                    else m = slope_prep(rt - x, rt - rf);
                end
                else if (rt == mf) begin
                    if (x < rf) m.deg = '0;
                    else if (x > rt) m.deg = DEG_ONE;
                    else m = slope_prep(x - rf, rt - rf);
                end
                else begin
                    m.deg = DEG_TWO;
                    m.bad = 1'b1;
                end
            end
            SHAPE_TRAP: begin
                if (x < rf || x > rt) m.deg = '0;
                else if (x < mf) m = slope_prep(x - rf, mf - rf);
                else if (x <= mt) m.deg = DEG_ONE;
                else m = slope_prep(rt - x, rt - mt);
            end
            default: begin
                m.deg = DEG_TWO;
                m.bad = 1'b1;
            end
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/fuzzy_rule_duty_controller_core.sv
// Top level of the fuzzy rule duty controller: rule memory, sequencer and serial divider.
//
//  channel   | signals                          | direction | transfer
//  ----------+----------------------------------+-----------+-------------------------
//  command   | start, busy, cmd                 | in        | start high, busy low
//  result    | done, res                        | out       | done high for one cycle
//  config    | psel penable pwrite paddr pwdata | in/out    | APB write, pready high
//
// An evaluation walks the N rules in turn and is shorter when a degree needs no division:
// each slope degree runs through one shared radix-2 divider at one quotient bit per cycle,
// and the final average finds its 38 quotient bits in the same divider.
// Rule state sits in one synchronous memory with a registered read; kind fields reset to
// absent through per-entry valid bits. The result receiver cannot stall.
`default_nettype none
module fuzzy_rule_duty_controller_core #(
    parameter int RULE_SLOTS = frdc_pkg::RULE_SLOTS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  frdc_pkg::cmd_t       cmd,
    output logic                 done,
    output frdc_pkg::res_t       res,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [3:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);
    // Memory word: delta kind, temp kind, singleton, delta points, temp points.
    localparam int MW = 2 + 2 + 16 + 64 + 64;

    // Configuration registers.
    logic [4:0]         rules_reg;
    logic [15:0]        step_reg;
    logic signed [15:0] limit_reg;
    logic               cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_reg <= 5'd16;
            step_reg  <= 16'd1;
            limit_reg <= 16'sh7FFF;
        end
        else if (cfg_wr)
        begin
            if (paddr[3:2] == frdc_pkg::REG_RULES) rules_reg <= pwdata[4:0];
            if (paddr[3:2] == frdc_pkg::REG_STEP)  step_reg  <= pwdata[15:0];
            if (paddr[3:2] == frdc_pkg::REG_LIMIT) limit_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            frdc_pkg::REG_RULES: prdata = {27'd0, rules_reg};
            frdc_pkg::REG_STEP:  prdata = {16'd0, step_reg};
            frdc_pkg::REG_LIMIT: prdata = {{16{limit_reg[15]}}, limit_reg};
            default:             prdata = '0;
        endcase
    end

    // Rule memory with a registered read, plus valid bits per side.
    logic [MW-1:0]         mem [RULE_SLOTS];
    logic [MW-1:0]         rd_data_reg;
    logic [RULE_SLOTS-1:0] tval_reg;
    logic [RULE_SLOTS-1:0] dval_reg;
    logic [RULE_SLOTS-1:0] sval_reg;
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [MW-1:0]         wdata;
    logic [IW-1:0]         raddr;

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    // State registers.
    frdc_pkg::state_t   state_reg, state_next;
    frdc_pkg::cmd_t     cmd_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      n_reg;
    logic [7:0]         err_reg, err_next;
    logic [16:0]        tdeg_reg, tdeg_next;
    logic [16:0]        sdeg_reg, sdeg_next;
    logic [21:0]        sumw_reg, sumw_next;
    logic [37:0]        summ_reg, summ_next;
    logic [15:0]        prod_reg, prod_next;
    // Shared restoring divider: remainder, quotient, divisor, step count.
    logic [38:0]        rem_reg, rem_next;
    logic [37:0]        quo_reg, quo_next;
    logic [37:0]        dvs_reg, dvs_next;
    logic [5:0]         cnt_reg, cnt_next;
    frdc_pkg::res_t     res_reg, res_next;
    logic               done_reg, done_next;

    frdc_pkg::mship_t   tm, dm;
    logic [1:0]         tkind, dkind;
    logic [15:0]        sing;
    logic [38:0]        rem_sh;
    logic [38:0]        rem_sub;
    logic [16:0]        smin;

    assign tkind = tval_reg[idx_reg[IW-1:0]] ? rd_data_reg[MW-3:MW-4] : 2'd0;
    assign dkind = dval_reg[idx_reg[IW-1:0]] ? rd_data_reg[MW-1:MW-2] : 2'd0;
    assign sing  = sval_reg[idx_reg[IW-1:0]] ? rd_data_reg[143:128] : 16'd0;
    assign tm = frdc_pkg::shape_eval(tkind, rd_data_reg[63:0], cmd_reg.temperature);
    assign dm = frdc_pkg::shape_eval(dkind, rd_data_reg[127:64], cmd_reg.delta_temp);
    assign rem_sh  = {rem_reg[37:0], quo_reg[37]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign smin = (dkind != 2'd0 && sdeg_reg < tdeg_reg) ? sdeg_reg : tdeg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frdc_pkg::ST_IDLE;
            err_reg   <= '0;
            done_reg  <= 1'b0;
            tval_reg  <= '0;
            dval_reg  <= '0;
            sval_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
            if (we)
            begin
                if (cmd_reg.opcode == frdc_pkg::OP_WR_TEMP)  tval_reg[waddr] <= 1'b1;
                if (cmd_reg.opcode == frdc_pkg::OP_WR_DELTA) dval_reg[waddr] <= 1'b1;
                if (cmd_reg.opcode == frdc_pkg::OP_WR_SING)  sval_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
            n_reg <= (32'(rules_reg) > RULE_SLOTS) ? CW'(RULE_SLOTS) : CW'(rules_reg);
        end
        tdeg_reg <= tdeg_next;
        sdeg_reg <= sdeg_next;
        sumw_reg <= sumw_next;
        summ_reg <= summ_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != frdc_pkg::ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

    // Sequencer: next state, memory access and datapath control.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        err_next = err_reg;
        tdeg_next = tdeg_reg;
        sdeg_next = sdeg_reg;
        sumw_next = sumw_reg;
        summ_next = summ_reg;
        prod_next = prod_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        done_next = 1'b0;
        we = 1'b0;
        waddr = IW'(cmd_reg.rule_index);
        raddr = idx_reg[IW-1:0];
        wdata = rd_data_reg;
        unique case (state_reg)
            frdc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = frdc_pkg::ST_READ;
                    idx_next = '0;
                    sumw_next = '0;
                    summ_next = '0;
                end
            end
            frdc_pkg::ST_READ:
            begin
                // Read-modify-write for stores; first rule fetch for evaluation.
                if (cmd_reg.opcode == frdc_pkg::OP_EVAL)
                begin
                    state_next = (n_reg == '0) ? frdc_pkg::ST_MUL : frdc_pkg::ST_TSETUP;
                end
                else
                begin
                    raddr = IW'(cmd_reg.rule_index);
                    state_next = frdc_pkg::ST_DONE;
                    idx_next = CW'(IW'(cmd_reg.rule_index));
                end
            end
            frdc_pkg::ST_TSETUP:
            begin
                if (tm.bad) err_next = err_reg + 8'd1;
                tdeg_next = tm.deg;
                if (tm.fixed) state_next = frdc_pkg::ST_DSETUP;
                else
                begin
                    // The numerator is below the divisor, so only the 15 fraction
                    // bits of the quotient remain to be found.
                    rem_next = {22'd0, tm.num};
                    quo_next = '0;
                    dvs_next = {21'd0, tm.den};
                    cnt_next = 6'd15;
                    state_next = frdc_pkg::ST_TDIV;
                end
            end
            frdc_pkg::ST_TDIV, frdc_pkg::ST_DDIV, frdc_pkg::ST_FDIV:
            begin
                // One quotient bit per cycle, starting at bit 37 for the final average.
                if (rem_sub[38]) rem_next = rem_sh;
                else rem_next = rem_sub;
                quo_next = {quo_reg[36:0], ~rem_sub[38]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    if (state_reg == frdc_pkg::ST_TDIV)
                    begin
                        tdeg_next = quo_reg[16:0];
                        state_next = frdc_pkg::ST_DSETUP;
                    end
                    else if (state_reg == frdc_pkg::ST_DDIV)
                    begin
                        sdeg_next = quo_reg[16:0];
                        state_next = frdc_pkg::ST_ACC;
                    end
                    else
                    begin
                        prod_next = quo_reg[15:0];
                        state_next = frdc_pkg::ST_SCALE;
                    end
                    rem_next = rem_reg;
                    quo_next = quo_reg;
                end
            end
            frdc_pkg::ST_DSETUP:
            begin
                if (dkind != 2'd0 && dm.bad) err_next = err_next + 8'd1;
                sdeg_next = dm.deg;
                if (dkind == 2'd0 || dm.fixed) state_next = frdc_pkg::ST_ACC;
                else
                begin
                    rem_next = {22'd0, dm.num};
                    quo_next = '0;
                    dvs_next = {21'd0, dm.den};
                    cnt_next = 6'd15;
                    state_next = frdc_pkg::ST_DDIV;
                end
            end
            frdc_pkg::ST_ACC:
            begin
                sumw_next = sumw_reg + 22'(smin);
                summ_next = summ_reg + 38'(smin) * 38'(sing);
                idx_next = idx_reg + CW'(1);
                raddr = IW'(idx_reg + CW'(1));
                if (idx_reg + CW'(1) == n_reg) state_next = frdc_pkg::ST_MUL;
                else state_next = frdc_pkg::ST_TSETUP;
            end
            frdc_pkg::ST_MUL:
            begin
                // Start the final average, or finish at once on zero weight.
                if (sumw_reg == '0)
                begin
                    res_next = '{duty_cycle: '0, error_total: err_reg, no_weight: 1'b1,
                                 over_temp: (cmd_reg.temperature >= limit_reg)};
                    done_next = 1'b1;
                    state_next = frdc_pkg::ST_IDLE;
                end
                else
                begin
                    rem_next = '0;
                    quo_next = summ_reg;
                    dvs_next = {16'd0, sumw_reg};
                    cnt_next = 6'd38;
                    state_next = frdc_pkg::ST_FDIV;
                end
            end
            frdc_pkg::ST_SCALE:
            begin
                res_next = '{duty_cycle: 32'(prod_reg) * 32'(step_reg),
                             error_total: err_reg, no_weight: 1'b0,
                             over_temp: (cmd_reg.temperature >= limit_reg)};
                done_next = 1'b1;
                state_next = frdc_pkg::ST_IDLE;
            end
            frdc_pkg::ST_DONE:
            begin
                // Merge the written fields into the word read last cycle.
                waddr = idx_reg[IW-1:0];
                we = (32'(cmd_reg.rule_index) < RULE_SLOTS);
                if (cmd_reg.opcode == frdc_pkg::OP_WR_TEMP)
                begin
                    wdata[MW-3:MW-4] = cmd_reg.shape_kind;
                    wdata[63:0] = {cmd_reg.range_to, cmd_reg.peak_to,
                                   cmd_reg.peak_from, cmd_reg.range_from};
                end
                else if (cmd_reg.opcode == frdc_pkg::OP_WR_DELTA)
                begin
                    wdata[MW-1:MW-2] = cmd_reg.shape_kind;
                    wdata[127:64] = {cmd_reg.range_to, cmd_reg.peak_to,
                                     cmd_reg.peak_from, cmd_reg.range_from};
                end
                else
                begin
                    wdata[143:128] = cmd_reg.singleton;
                end
                if (!tval_reg[idx_reg[IW-1:0]]) wdata[MW-3:MW-4] = (cmd_reg.opcode ==
                    frdc_pkg::OP_WR_TEMP) ? cmd_reg.shape_kind : 2'd0;
                if (!dval_reg[idx_reg[IW-1:0]]) wdata[MW-1:MW-2] = (cmd_reg.opcode ==
                    frdc_pkg::OP_WR_DELTA) ? cmd_reg.shape_kind : 2'd0;
                res_next = '{duty_cycle: '0, error_total: err_reg, no_weight: 1'b0,
                             over_temp: 1'b0};
                done_next = 1'b1;
                state_next = frdc_pkg::ST_IDLE;
            end
            default: state_next = frdc_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
